@@ rtl/core/stcs_pkg.sv @@
// ----------------------------------------------------------------------------
// stcs_pkg
// Shared widths, codes, sequencer states and the saturating accumulate
// function for the suffix tree context scorer.
// ----------------------------------------------------------------------------
package stcs_pkg;

  // Field widths of the input and result words.
  localparam int MODE_W = 2;
  localparam int IDX_W  = 10;
  localparam int SYM_W  = 5;
  localparam int LP_W   = 24;
  localparam int SUM_W  = 40;

  // Width of one tree table entry: child link above log-probability.
  localparam int ENT_W  = IDX_W + LP_W;

  // Input word kinds.
  localparam logic [MODE_W-1:0] MODE_NODE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BACK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SCORE = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WALK,
    ST_FINAL,
    ST_EMIT
  } state_t;

  // Add a Q8.16 value to a Q24.16 sum, clamping to the signed sum range.
  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] acc,
    input logic signed [LP_W-1:0]  val
  );
    logic [SUM_W:0] s;
    s = {acc[SUM_W-1], acc} + {{(SUM_W + 1 - LP_W){val[LP_W-1]}}, val};
    if (s[SUM_W] != s[SUM_W-1]) begin
      if (s[SUM_W]) begin
        return {1'b1, {(SUM_W - 1){1'b0}}};
      end else begin
        return {1'b0, {(SUM_W - 1){1'b1}}};
      end
    end
    return s[SUM_W-1:0];
  endfunction

endpackage

@@ rtl/core/stcs_ram.sv @@
// ----------------------------------------------------------------------------
// stcs_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module stcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/suffix_tree_context_scorer.sv @@
// Load words are accepted back to back. A score word holds in_stall high until
// the sequencer is back in IDLE; its walk covers 0 to MAX_DEPTH tree levels,
// bound by one tree table read a cycle. A word that ends a sequence also passes
// through EMIT, and waits there while the previous result is held by out_stall.
// Reset (synchronous, active low) clears sums, history and control state;
// the tree and background tables hold no defined value until loaded.
// ----------------------------------------------------------------------------
// suffix_tree_context_scorer
// Scores a symbol sequence against a flattened probabilistic suffix tree,
// keeping saturating model and background log-probability sums.
// ----------------------------------------------------------------------------
module suffix_tree_context_scorer
  import stcs_pkg::*;
#(
  parameter int ALPHABET  = 20,
  parameter int NODES     = 1024,
  parameter int MAX_DEPTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic [IDX_W-1:0]        in_node_index,
  input  logic [SYM_W-1:0]        in_letter,
  input  logic [IDX_W-1:0]        in_child_link,
  input  logic signed [LP_W-1:0]  in_log_prob,
  input  logic [SYM_W-1:0]        in_symbol,
  input  logic                    in_first,
  input  logic                    in_last,
  // Result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [SUM_W-1:0] out_model_score,
  output logic signed [SUM_W-1:0] out_background_score
);

  localparam int NW  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int TD  = NODES * ALPHABET;
  localparam int AW  = $clog2(TD);
  localparam int BW  = $clog2(ALPHABET);
  localparam int HCW = $clog2(MAX_DEPTH + 1);

  // Flat table address of one (node, column) pair.
  function automatic logic [AW-1:0] addr_of(input logic [NW-1:0] node,
                                            input logic [SYM_W-1:0] col);
    return AW'(node) * AW'(ALPHABET) + AW'(col);
  endfunction

  state_t state_r, state_nxt;

  logic [SYM_W-1:0]        hist_r [MAX_DEPTH];
  logic [SYM_W-1:0]        walk_r [MAX_DEPTH];
  logic [HCW-1:0]          hcnt_r;
  logic [HCW-1:0]          k_r;
  logic [NW-1:0]           node_r;
  logic [SYM_W-1:0]        sym_r;
  logic                    last_r;
  logic                    add_r;
  logic signed [SUM_W-1:0] model_r;
  logic signed [SUM_W-1:0] back_r;
  logic                    out_valid_r;
  logic signed [SUM_W-1:0] out_model_r;
  logic signed [SUM_W-1:0] out_back_r;

  logic                    in_acc;
  logic                    sym_ok;
  logic                    node_ld;
  logic                    back_ld;
  logic [ENT_W-1:0]        tab_q;
  logic [LP_W-1:0]         back_q;
  logic [IDX_W-1:0]        link_q;
  logic                    link_ok;
  logic [NW-1:0]           link_node;
  logic                    more;
  logic [NW-1:0]           rd_node;
  logic [SYM_W-1:0]        rd_col;
  logic                    slot_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign sym_ok    = (int'(in_symbol) < ALPHABET);
  assign node_ld   = in_acc && (in_mode == MODE_NODE) && (int'(in_node_index) < NODES)
                     && (int'(in_letter) < ALPHABET);
  assign back_ld   = in_acc && (in_mode == MODE_BACK) && (int'(in_letter) < ALPHABET);
  assign slot_free = !out_valid_r || !out_stall;

  // Child link returned by the last tree read, and whether the walk goes on.
  assign link_q    = tab_q[ENT_W-1:LP_W];
  assign link_ok   = (link_q != '0) && (int'(link_q) < NODES);
  assign link_node = NW'(link_q);
  assign more      = link_ok && (k_r < hcnt_r);

  // Tree table: child link and log-probability share one word.
  stcs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TD)
  ) u_tree_ram (
    .clk   (clk),
    .we    (node_ld),
    .waddr (addr_of(NW'(in_node_index), in_letter)),
    .wdata ({in_child_link, in_log_prob}),
    .raddr (addr_of(rd_node, rd_col)),
    .rdata (tab_q)
  );

  // Background table, read continuously at the current symbol.
  stcs_ram #(
    .WIDTH (LP_W),
    .DEPTH (ALPHABET)
  ) u_back_ram (
    .clk   (clk),
    .we    (back_ld),
    .waddr (BW'(in_letter)),
    .wdata (in_log_prob),
    .raddr (BW'(sym_r)),
    .rdata (back_q)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_mode == MODE_SCORE)) begin
          state_nxt = sym_ok ? ST_START : ST_FINAL;
        end
      end
      ST_START: begin
        state_nxt = (hcnt_r != '0) ? ST_WALK : ST_FINAL;
      end
      ST_WALK: begin
        state_nxt = more ? ST_WALK : ST_FINAL;
      end
      ST_FINAL: begin
        state_nxt = last_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Tree read address: next link on the walk, or the symbol at the final node.
  always_comb begin
    rd_node = node_r;
    rd_col  = sym_r;
    case (state_r)
      ST_START: begin
        rd_node = '0;
        rd_col  = (hcnt_r != '0) ? hist_r[0] : sym_r;
      end
      ST_WALK: begin
        rd_node = link_ok ? link_node : node_r;
        rd_col  = more ? walk_r[0] : sym_r;
      end
      default: begin
        rd_node = node_r;
        rd_col  = sym_r;
      end
    endcase
  end

  // State register and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hcnt_r      <= '0;
      model_r     <= '0;
      back_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      // Result word: loaded on the way out of EMIT, cleared when taken.
      if ((state_r == ST_EMIT) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc && (in_mode == MODE_SCORE) && in_first) begin
            hcnt_r  <= '0;
            model_r <= '0;
            back_r  <= '0;
            for (int i = 0; i < MAX_DEPTH; i++) begin
              hist_r[i] <= '0;
            end
          end
        end
        ST_FINAL: begin
          // Accumulate both sums and push the symbol into the history.
          if (add_r) begin
            model_r   <= sat_add(model_r, tab_q[LP_W-1:0]);
            back_r    <= sat_add(back_r, back_q);
            hist_r[0] <= sym_r;
            for (int i = 1; i < MAX_DEPTH; i++) begin
              hist_r[i] <= hist_r[i-1];
            end
            if (hcnt_r != HCW'(MAX_DEPTH)) begin
              hcnt_r <= hcnt_r + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Walk and result payload registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_mode == MODE_SCORE)) begin
          sym_r  <= in_symbol;
          last_r <= in_last;
          add_r  <= sym_ok;
          node_r <= '0;
        end
      end
      ST_START: begin
        // Copy the older history into the walk line; the newest is in flight.
        k_r <= HCW'(1);
        for (int i = 0; i < MAX_DEPTH; i++) begin
          if (i == MAX_DEPTH - 1) begin
            walk_r[i] <= '0;
          end else begin
            walk_r[i] <= hist_r[i+1];
          end
        end
      end
      ST_WALK: begin
        if (link_ok) begin
          node_r <= link_node;
        end
        if (more) begin
          k_r <= k_r + 1'b1;
          for (int i = 0; i < MAX_DEPTH; i++) begin
            if (i == MAX_DEPTH - 1) begin
              walk_r[i] <= '0;
            end else begin
              walk_r[i] <= walk_r[i+1];
            end
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_model_r <= model_r;
          out_back_r  <= back_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid            = out_valid_r;
  assign out_model_score      = out_model_r;
  assign out_background_score = out_back_r;

endmodule
